// ===== src/sine_polynomial_approx_macros.svh =====
// ----------------------------------------------------------------------------
// sine polynomial approximation assertion macros
// Shared concurrent assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef SINE_POLYNOMIAL_APPROX_MACROS_SVH
`define SINE_POLYNOMIAL_APPROX_MACROS_SVH

// same-cycle implication
`define SINPA_ASSERT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SINPA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sinpa_pkg.sv =====
// ----------------------------------------------------------------------------
// sinpa_pkg
// Constants and inter-stage types for the fixed-point sine evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sinpa_pkg;

  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 32;

  // reduced angle, unsigned Q56, always below two pi
  localparam int X_W   = 59;
  localparam int X30_W = 31;
  localparam int Z_W   = 32;
  localparam int T1_W  = 26;
  localparam int T2_W  = 30;
  localparam int T3_W  = 33;

  // quotient of (|angle| << 32) / two pi fits in this many bits
  localparam int REM_STEPS = 5;

  localparam logic [63:0] PI_Q56      = 64'h0324_3F6A_8885_A309;
  localparam logic [63:0] TWO_PI_Q56  = PI_Q56 << 1;
  localparam logic [63:0] HALF_PI_Q56 = PI_Q56 >> 1;

  localparam logic [X_W-1:0] PI_X      = PI_Q56[X_W-1:0];
  localparam logic [X_W-1:0] TWO_PI_X  = TWO_PI_Q56[X_W-1:0];
  localparam logic [X_W-1:0] HALF_PI_X = HALF_PI_Q56[X_W-1:0];
  localparam logic [X_W-1:0] TINY_X    = X_W'(64'd1 << 29);

  localparam logic [63:0] RND25 = 64'd1 << 25;
  localparam logic [63:0] RND29 = 64'd1 << 29;
  localparam logic [64:0] RND31 = 65'd1 << 31;

  localparam logic [63:0] C3_Q32  = 64'd715827883;
  localparam logic [63:0] C5_Q32  = 64'd35791394;
  localparam logic [63:0] C7_Q32  = 64'd852176;
  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

  localparam logic [T3_W-1:0] ONE_Q30 = T3_W'(64'd1 << 30);

  typedef struct packed {
    logic             neg;
    logic             tiny;
    logic [X30_W-1:0] x30;
  } red_t;

  typedef struct packed {
    logic             neg;
    logic             tiny;
    logic [X30_W-1:0] x30;
    logic [T3_W-1:0]  t3;
  } poly_t;

endpackage

// ===== src/sinpa_reduce.sv =====
// ----------------------------------------------------------------------------
// sinpa_reduce
// Range reduction: modulo two pi by restoring steps, sign fix, fold to
// [0, pi/2], rounding to Q30 and small-angle detect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sine_polynomial_approx_macros.svh"

module sinpa_reduce import sinpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  logic [ANGLE_W-1:0] up_angle,
  output logic               dn_valid,
  input  logic               dn_stall,
  output red_t               dn_data
);

  localparam int ST_FIX  = REM_STEPS;
  localparam int ST_PI   = REM_STEPS + 1;
  localparam int ST_HALF = REM_STEPS + 2;
  localparam int ST_RND  = REM_STEPS + 3;
  localparam int NST     = REM_STEPS + 4;

  logic [NST-1:0] v_r, v_nxt, en;

  logic [63:0]    rem_r [REM_STEPS];
  logic           nin_r [REM_STEPS];
  logic [31:0]    mag;

  logic [X_W-1:0] fix_r, fix_nxt, rem_x;
  logic [X_W-1:0] pi_r, pi_nxt;
  logic           negp_r;
  logic [X_W-1:0] half_r, half_nxt;
  logic           negh_r;
  logic [X_W:0]   x_rnd;
  red_t           red_r, red_nxt;

  // per-stage enable: a stage moves when empty or when the next one moves
  always_comb begin
    en[NST-1] = !v_r[NST-1] || !dn_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? up_valid : v_r[0];
    for (int i = 1; i < NST; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign mag = up_angle[ANGLE_W-1] ? (~up_angle + 32'd1) : up_angle;

  // one quotient bit per stage, largest multiple first
  for (genvar i = 0; i < REM_STEPS; i++) begin : g_rem
    localparam logic [63:0] STEP_C = TWO_PI_Q56 << (REM_STEPS - 1 - i);
    logic [63:0] rem_in;
    logic        nin_in;
    if (i == 0) begin : g_first
      assign rem_in = {mag, 32'd0};
      assign nin_in = up_angle[ANGLE_W-1];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nin_in = nin_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem_r[i] <= (rem_in >= STEP_C) ? (rem_in - STEP_C) : rem_in;
        nin_r[i] <= nin_in;
      end
    end
  end

  assign rem_x = rem_r[REM_STEPS-1][X_W-1:0];

  always_comb begin
    fix_nxt = rem_x;
    if (nin_r[REM_STEPS-1] && (rem_x != '0)) begin
      fix_nxt = TWO_PI_X - rem_x;
    end
  end

  // exactly pi stays in the lower half
  assign pi_nxt   = (fix_r > PI_X) ? (fix_r - PI_X) : fix_r;
  assign half_nxt = (pi_r > HALF_PI_X) ? (PI_X - pi_r) : pi_r;

  always_comb begin
    x_rnd        = {1'b0, half_r} + (X_W+1)'(RND25);
    red_nxt.neg  = negh_r;
    red_nxt.tiny = half_r < TINY_X;
    red_nxt.x30  = x_rnd[X30_W+25:26];
  end

  always_ff @(posedge clk) begin
    if (en[ST_FIX]) begin
      fix_r <= fix_nxt;
    end
    if (en[ST_PI]) begin
      pi_r   <= pi_nxt;
      negp_r <= fix_r > PI_X;
    end
    if (en[ST_HALF]) begin
      half_r <= half_nxt;
      negh_r <= negp_r;
    end
    if (en[ST_RND]) begin
      red_r <= red_nxt;
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[NST-1];
  assign dn_data  = red_r;

  `SINPA_ASSERT(a_rem_below_two_pi, clk, rst_n, v_r[REM_STEPS-1], rem_r[REM_STEPS-1] < TWO_PI_Q56, "remainder not below two pi")
  `SINPA_ASSERT(a_fold_quadrant, clk, rst_n, v_r[ST_HALF], half_r <= HALF_PI_X, "folded angle above pi/2")
  `SINPA_ASSERT_NEXT(a_take_item, clk, rst_n, up_valid && !up_stall, v_r[0], "accepted item lost at entry")

endmodule

// ===== src/sinpa_poly.sv =====
// ----------------------------------------------------------------------------
// sinpa_poly
// Square of the reduced angle and the three Horner steps of the odd
// polynomial, one multiply, one rounding or one round-and-subtract per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sine_polynomial_approx_macros.svh"

module sinpa_poly import sinpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_stall,
  input  red_t  up_data,
  output logic  dn_valid,
  input  logic  dn_stall,
  output poly_t dn_data
);

  localparam int NST  = 8;
  localparam int NZ   = 5;

  logic [NST-1:0] v_r, v_nxt, en;
  red_t           ctx_r [NST];

  logic [2*X30_W-1:0] sq_r;
  logic [Z_W-1:0]     z_r [NZ];
  logic [63:0]        sq_sum;
  logic [51:0]        m1_r;
  logic [T1_W-1:0]    t1_r, t1_nxt;
  logic [57:0]        m2_r;
  logic [T2_W-1:0]    t2_r, t2_nxt;
  logic [61:0]        m3_r;
  logic [T3_W-1:0]    t3_r, t3_nxt;
  logic [63:0]        d1, d2, d3;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !dn_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? up_valid : v_r[0];
    for (int i = 1; i < NST; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // rounded q30 shifts of each product
  always_comb begin
    sq_sum = 64'(sq_r) + RND29;
    d1     = (64'(m1_r) + RND29) >> 30;
    d2     = (64'(m2_r) + RND29) >> 30;
    d3     = (64'(m3_r) + RND29) >> 30;
    t1_nxt = T1_W'(C5_Q32 - d1);
    t2_nxt = T2_W'(C3_Q32 - d2);
    t3_nxt = T3_W'(ONE_Q32 - d3);
  end

  // z_r[i] travels with stage i+1
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ctx_r[0] <= up_data;
      sq_r     <= up_data.x30 * up_data.x30;
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        ctx_r[i] <= ctx_r[i-1];
      end
    end
    if (en[1]) begin
      z_r[0] <= sq_sum[Z_W+29:30];
    end
    for (int i = 1; i < NZ; i++) begin
      if (en[i+1]) begin
        z_r[i] <= z_r[i-1];
      end
    end
    if (en[2]) begin
      m1_r <= z_r[0] * C7_Q32[19:0];
    end
    if (en[3]) begin
      t1_r <= t1_nxt;
    end
    if (en[4]) begin
      m2_r <= z_r[2] * t1_r;
    end
    if (en[5]) begin
      t2_r <= t2_nxt;
    end
    if (en[6]) begin
      m3_r <= z_r[4] * t2_r;
    end
    if (en[7]) begin
      t3_r <= t3_nxt;
    end
  end

  assign up_stall     = !en[0];
  assign dn_valid     = v_r[NST-1];
  assign dn_data.neg  = ctx_r[NST-1].neg;
  assign dn_data.tiny = ctx_r[NST-1].tiny;
  assign dn_data.x30  = ctx_r[NST-1].x30;
  assign dn_data.t3   = t3_r;

  `SINPA_ASSERT(a_t3_bound, clk, rst_n, v_r[NST-1], t3_r <= T3_W'(ONE_Q32), "horner result above one")

endmodule

// ===== src/sinpa_out.sv =====
// ----------------------------------------------------------------------------
// sinpa_out
// Final multiply by the angle, rounding to Q30, saturation, sign and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sinpa_out import sinpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_stall,
  input  poly_t             up_data,
  output logic              dn_valid,
  input  logic              dn_stall,
  output logic [SINE_W-1:0] dn_sine
);

  localparam int NST = 2;

  logic [NST-1:0]      v_r, v_nxt, en;
  logic [63:0]         pm_r;
  logic                neg_r, tiny_r;
  logic [X30_W-1:0]    x30_r;
  logic [64:0]         pm_rnd;
  logic [T3_W-1:0]     res, res_sat;
  logic [SINE_W-1:0]   sine_r, sine_nxt;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !dn_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? up_valid : v_r[0];
    for (int i = 1; i < NST; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // tiny angles bypass the polynomial
  always_comb begin
    pm_rnd   = {1'b0, pm_r} + RND31;
    res      = tiny_r ? T3_W'(x30_r) : pm_rnd[64:32];
    res_sat  = (res > ONE_Q30) ? ONE_Q30 : res;
    sine_nxt = neg_r ? (~res_sat[SINE_W-1:0] + 32'd1) : res_sat[SINE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pm_r   <= up_data.x30 * up_data.t3;
      neg_r  <= up_data.neg;
      tiny_r <= up_data.tiny;
      x30_r  <= up_data.x30;
    end
    if (en[1]) begin
      sine_r <= sine_nxt;
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[NST-1];
  assign dn_sine  = sine_r;

endmodule

// ===== src/sine_polynomial_approx.sv =====
// ----------------------------------------------------------------------------
// sine_polynomial_approx
// Fixed-point sine of a Q8.24 angle in Q1.30 by a seventh-order polynomial.
// ----------------------------------------------------------------------------
// Takes one angle per cycle and returns its sine, one item per clock
// when the output is not stalled. Nine stages reduce the angle (five
// restoring steps of the modulo two pi, then sign fix, two folds and
// rounding), eight evaluate the square and the Horner chain with one
// multiply or one rounding step per stage, and two form the final
// product, saturate and hold the result. Each stage holds an item while
// stalled and fills any bubble ahead of it.
`timescale 1ns / 1ps
`include "sine_polynomial_approx_macros.svh"

module sine_polynomial_approx import sinpa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SINE_W-1:0]  out_sine
);

  logic              red_valid, red_stall;
  red_t              red_data;
  logic              poly_valid, poly_stall;
  poly_t             poly_data;
  logic [SINE_W-1:0] sine;

  sinpa_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_angle (in_angle),
    .dn_valid (red_valid),
    .dn_stall (red_stall),
    .dn_data  (red_data)
  );

  sinpa_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (red_valid),
    .up_stall (red_stall),
    .up_data  (red_data),
    .dn_valid (poly_valid),
    .dn_stall (poly_stall),
    .dn_data  (poly_data)
  );

  sinpa_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (poly_valid),
    .up_stall (poly_stall),
    .up_data  (poly_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_sine  (sine)
  );

  assign out_sine = $signed(sine);

  `SINPA_ASSERT(a_out_saturated, clk, rst_n, out_valid, (out_sine <= 32'sd1073741824) && (out_sine >= -32'sd1073741824), "sine outside plus or minus one")

endmodule

// ===== tb/sine_polynomial_approx_tb.sv =====
// ----------------------------------------------------------------------------
// sine_polynomial_approx_tb
// Self-checking bench for the fixed-point sine evaluator: Q8.24 angles in,
// Q1.30 sines out, each result checked against a bit-exact in-bench
// predictor, with random idle bursts on both sides of the handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_polynomial_approx_tb import sinpa_pkg::*; ();

  // reduction constants in unsigned Q56, polynomial coefficients in Q32
  localparam logic [63:0] PI_RAD_Q56      = 64'h0324_3F6A_8885_A309;
  localparam logic [63:0] TWO_PI_RAD_Q56  = PI_RAD_Q56 << 1;
  localparam logic [63:0] HALF_PI_RAD_Q56 = PI_RAD_Q56 >> 1;
  localparam logic [63:0] TINY_RAD_Q56    = 64'd1 << 29;
  localparam logic [63:0] UNITY_Q30       = 64'd1 << 30;
  localparam logic [63:0] UNITY_Q32       = 64'd1 << 32;
  localparam logic [63:0] INV6_Q32        = 64'd715827883;
  localparam logic [63:0] INV120_Q32      = 64'd35791394;
  localparam logic [63:0] INV5040_Q32     = 64'd852176;

  localparam int MAX_K      = 81;    // largest multiple of pi/2 inside the angle range
  localparam int DRAIN_MAX  = 2000;
  localparam int SETTLE     = 25;
  localparam int PRINT_MAX  = 20;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SINE_W-1:0]  out_sine;

  logic [SINE_W-1:0]  sine_expect_q[$];
  logic [ANGLE_W-1:0] angle_sent_q[$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int err_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_tiny = 0;
  int n_folded_neg = 0;

  sine_polynomial_approx dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_angle (in_angle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sine (out_sine)
  );

  always #1 clk = ~clk;

  // one horner step: c - z * t, all fixed point
  function automatic logic [63:0] horner_term(input logic [63:0] c, input logic [63:0] z,
                                              input logic [63:0] t);
    return c - ((z * t + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic [SINE_W-1:0] predict_sine(input logic [ANGLE_W-1:0] a,
                                                     output bit tiny, output bit neg_out);
    logic [63:0] mag;
    logic [63:0] x;
    logic [63:0] x30;
    logic [63:0] z;
    logic [63:0] t;
    logic [63:0] res;
    bit          neg_in;
    neg_in = a[ANGLE_W-1];
    mag = neg_in ? {32'd0, (~a + 32'd1)} : {32'd0, a};
    x = (mag << 32) % TWO_PI_RAD_Q56;
    if (neg_in && x != 64'd0) x = TWO_PI_RAD_Q56 - x;
    neg_out = 1'b0;
    if (x > PI_RAD_Q56) begin
      neg_out = 1'b1;
      x = x - PI_RAD_Q56;
    end
    if (x > HALF_PI_RAD_Q56) x = PI_RAD_Q56 - x;
    x30 = (x + (64'd1 << 25)) >> 26;
    tiny = x < TINY_RAD_Q56;
    if (tiny) begin
      res = x30;
    end else begin
      z = (x30 * x30 + (64'd1 << 29)) >> 30;
      t = horner_term(INV120_Q32, z, INV5040_Q32);
      t = horner_term(INV6_Q32, z, t);
      t = horner_term(UNITY_Q32, z, t);
      res = (x30 * t + (64'd1 << 31)) >> 32;
    end
    if (res > UNITY_Q30) res = UNITY_Q30;
    return neg_out ? (~res[31:0] + 32'd1) : res[31:0];
  endfunction

  // angle nearest to k * pi/2 in Q8.24, nudged by a few lsb
  function automatic logic [ANGLE_W-1:0] angle_near_half_pi(input int unsigned k, input bit neg,
                                                            input int offset);
    logic [63:0] prod;
    logic [31:0] mag;
    prod = (64'(k) * HALF_PI_RAD_Q56 + (64'd1 << 31)) >> 32;
    mag = prod[31:0] + 32'(offset);
    return neg ? (~mag + 32'd1) : mag;
  endfunction

  function automatic logic [ANGLE_W-1:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return $urandom;
    end else if (pick < 75) begin
      return angle_near_half_pi($urandom_range(0, MAX_K), $urandom_range(0, 1),
                                int'($urandom_range(0, 6)) - 3);
    end else begin
      // within about eight radians either way
      return 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
    end
  endfunction

  task automatic report_error(input string msg);
    if (err_count < PRINT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // append one expected sine and its angle at the tail of the queues
  task automatic enqueue_expect(input logic [SINE_W-1:0] sine, input logic [ANGLE_W-1:0] a);
    sine_expect_q = {sine_expect_q, sine};
    angle_sent_q  = {angle_sent_q, a};
  endtask

  task automatic send_angle(input logic [ANGLE_W-1:0] a);
    bit          tiny;
    bit          neg;
    logic [31:0] sine;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sine = predict_sine(a, tiny, neg);
    enqueue_expect(sine, a);
    n_sent++;
    if (tiny) n_tiny++;
    if (neg) n_folded_neg++;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sine_expect_q.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sine_expect_q.size() == 0) begin
        report_error($sformatf("unexpected item, sine 0x%08h", out_sine));
      end else begin
        if (out_sine !== sine_expect_q[0])
          report_error($sformatf("angle 0x%08h: sine 0x%08h, expected 0x%08h",
                                 angle_sent_q[0], out_sine, sine_expect_q[0]));
        void'(sine_expect_q.pop_front());
        void'(angle_sent_q.pop_front());
        n_checked++;
      end
    end
  end

  // downstream stall bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_directed();
    send_angle(32'h0000_0000);
    send_angle(32'h0000_0001);
    send_angle(32'hFFFF_FFFF);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(32'h5555_5555);
    send_angle(32'hAAAA_AAAA);
    for (int k = 1; k <= 8; k++) send_angle(angle_near_half_pi(k, 1'b0, 0));
    for (int k = 1; k <= 4; k++) send_angle(angle_near_half_pi(k, 1'b1, 0));
    // either side of pi and two pi
    send_angle(angle_near_half_pi(2, 1'b0, -1));
    send_angle(angle_near_half_pi(2, 1'b0, 1));
    send_angle(angle_near_half_pi(4, 1'b1, -1));
    send_angle(angle_near_half_pi(4, 1'b1, 1));
  endtask

  task automatic test_random_stream(input int n);
    for (int i = 0; i < n; i++) send_angle(random_angle());
  endtask

  task automatic test_drain_pause(input int rounds, input int per_round);
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i < per_round; i++) send_angle(random_angle());
      wait_drained();
    end
  endtask

  task automatic test_back_to_back(input int n);
    idle_on = 1'b0;
    for (int i = 0; i < n; i++) send_angle(random_angle());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_stream(1000);
    test_drain_pause(3, 20);
    test_back_to_back(390);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sine_expect_q.size() != 0)
      report_error($sformatf("%0d items never came out", sine_expect_q.size()));

    $display("sent %0d angles (directed extremes, near multiples of pi/2, full range),",
             n_sent);
    $display("checked %0d sines; %0d took the tiny path, %0d the negative half",
             n_checked, n_tiny, n_folded_neg);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
